>>> rtl/core/rgbhsl_pkg.sv
// Payload types for the RGB to HSL pixel converter.
package rgbhsl_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [12:0] saturation;
    logic [8:0]  lightness;
  } hsl_pix_t;

endpackage

>>> rtl/core/rgb_to_hsl_pixel.sv
// RGB to HSL pixel converter: min/max stage, dividend stage, bit-serial divider pipeline.
// The divider pipeline resolves one restoring divider bit per stage.
// Throughput: one pixel per cycle while the skid register is empty; a stalled result moves
// into the skid register, which halts the pipeline, so in_ready is a register output.
// Reset (synchronous, active low) clears all valid bits; pixel data registers are not reset.
module rgb_to_hsl_pixel
  import rgbhsl_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rgb_pix_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hsl_pix_t out_data
);

  localparam int SCALE_W = 6 + HUE_FRAC_BITS;
  localparam int HNUM_W  = SCALE_W + 8;
  localparam int SNUM_W  = SAT_FRAC_BITS + 8;
  localparam int DIV_W   = (HNUM_W > SNUM_W) ? HNUM_W : SNUM_W;
  localparam int HUE_W   = SCALE_W + 3;

  localparam logic [HNUM_W-1:0] HSCALE  = HNUM_W'(60) << HUE_FRAC_BITS;
  localparam logic [HUE_W-1:0]  SECTOR  = HUE_W'(60) << HUE_FRAC_BITS;
  localparam logic [HUE_W-1:0]  BASE_G  = SECTOR << 1;
  localparam logic [HUE_W-1:0]  BASE_B  = SECTOR << 2;
  localparam logic [HUE_W-1:0]  BASE_WR = (SECTOR << 2) + (SECTOR << 1);

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

  typedef struct packed {
    sector_t    sector;
    logic       neg;
    logic       gray;
    logic [8:0] light;
    logic [7:0] hdiv;
    logic [7:0] sdiv;
  } tag_t;

  typedef struct packed {
    logic [DIV_W-1:0] hnum;
    logic [DIV_W-1:0] snum;
    logic [DIV_W-1:0] hquo;
    logic [DIV_W-1:0] squo;
    logic [7:0]       hrem;
    logic [7:0]       srem;
  } divst_t;

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [8:0] div_bit(logic [7:0] rem, logic nb, logic [7:0] dvs);
    logic [8:0] trial;
    logic [8:0] diff;
    logic [8:0] res;
    trial = {rem, nb};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      res = {1'b1, diff[7:0]};
    end else begin
      res = {1'b0, trial[7:0]};
    end
    return res;
  endfunction

  logic en;

  // Stage A: channel extremes, sector choice and the divider operands.
  logic       a_v_r;
  tag_t       a_tag_r;
  logic [7:0] a_mag_r;
  tag_t       a_tag_nxt;
  logic [7:0] a_mag_nxt;

  always_comb begin
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] p;
    logic [7:0] q;
    logic [8:0] light;
    logic [8:0] den;
    mx = in_data.red;
    mn = in_data.red;
    if (in_data.green > mx) mx = in_data.green;
    if (in_data.blue > mx) mx = in_data.blue;
    if (in_data.green < mn) mn = in_data.green;
    if (in_data.blue < mn) mn = in_data.blue;
    light = {1'b0, mx} + {1'b0, mn};
    den   = (light >= 9'd255) ? (9'd510 - light) : light;
    // Ties for the maximum go to blue, then green.
    if (in_data.blue == mx) begin
      a_tag_nxt.sector = SEC_BLUE;
      p = in_data.red;
      q = in_data.green;
    end else if (in_data.green == mx) begin
      a_tag_nxt.sector = SEC_GREEN;
      p = in_data.blue;
      q = in_data.red;
    end else begin
      a_tag_nxt.sector = SEC_RED;
      p = in_data.green;
      q = in_data.blue;
    end
    a_tag_nxt.neg   = (p < q);
    a_mag_nxt       = (p >= q) ? (p - q) : (q - p);
    a_tag_nxt.gray  = (mx == mn);
    a_tag_nxt.light = light;
    a_tag_nxt.hdiv  = mx - mn;
    a_tag_nxt.sdiv  = den[7:0];
  end

  // Divider pipeline: entry 0 holds the dividends, entry k+1 has k+1 quotient bits.
  logic   dv_v_r   [0:DIV_W];
  tag_t   dv_tag_r [0:DIV_W];
  divst_t dv_r     [0:DIV_W];
  divst_t dv_nxt   [0:DIV_W];

  always_comb begin
    logic [8:0] hb;
    logic [8:0] sb;
    dv_nxt[0].hnum = DIV_W'(HNUM_W'(a_mag_r) * HSCALE);
    dv_nxt[0].snum = DIV_W'(SNUM_W'(a_tag_r.hdiv) << SAT_FRAC_BITS);
    dv_nxt[0].hquo = '0;
    dv_nxt[0].squo = '0;
    dv_nxt[0].hrem = '0;
    dv_nxt[0].srem = '0;
    for (int k = 0; k < DIV_W; k++) begin
      hb = div_bit(dv_r[k].hrem, dv_r[k].hnum[DIV_W-1-k], dv_tag_r[k].hdiv);
      sb = div_bit(dv_r[k].srem, dv_r[k].snum[DIV_W-1-k], dv_tag_r[k].sdiv);
      dv_nxt[k+1].hnum = dv_r[k].hnum;
      dv_nxt[k+1].snum = dv_r[k].snum;
      dv_nxt[k+1].hquo = {dv_r[k].hquo[DIV_W-2:0], hb[8]};
      dv_nxt[k+1].squo = {dv_r[k].squo[DIV_W-2:0], sb[8]};
      dv_nxt[k+1].hrem = hb[7:0];
      dv_nxt[k+1].srem = sb[7:0];
    end
  end

  // Final stage: sector offset, red wrap and gray override.
  logic     f_v_r;
  hsl_pix_t f_data_r;
  hsl_pix_t f_data_nxt;

  always_comb begin
    logic [HUE_W-1:0]    t;
    logic [HUE_W-1:0]    hue;
    logic [HUE_W+14:0]   hue_ext;
    tag_t                tg;
    tg = dv_tag_r[DIV_W];
    t  = HUE_W'(dv_r[DIV_W].hquo[SCALE_W-1:0]);
    case (tg.sector)
      SEC_BLUE:  hue = tg.neg ? (BASE_B - t) : (BASE_B + t);
      SEC_GREEN: hue = tg.neg ? (BASE_G - t) : (BASE_G + t);
      default:   hue = (tg.neg && (t != '0)) ? (BASE_WR - t) : t;
    endcase
    if (tg.gray) begin
      hue = '0;
    end
    hue_ext                = {15'd0, hue};
    f_data_nxt.hue         = hue_ext[14:0];
    f_data_nxt.saturation  = tg.gray ? 13'd0 : dv_r[DIV_W].squo[12:0];
    f_data_nxt.lightness   = tg.light;
  end

  // Output register plus skid register; the pipeline runs while the skid is empty.
  logic     out_v_r;
  hsl_pix_t out_data_r;
  logic     skid_v_r;
  hsl_pix_t skid_data_r;

  assign en        = !skid_v_r;
  assign in_ready  = en;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      for (int k = 0; k <= DIV_W; k++) begin
        dv_v_r[k] <= 1'b0;
      end
      f_v_r    <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        a_v_r     <= in_valid;
        dv_v_r[0] <= a_v_r;
        for (int k = 0; k < DIV_W; k++) begin
          dv_v_r[k+1] <= dv_v_r[k];
        end
        f_v_r <= dv_v_r[DIV_W];
      end
      if (!out_v_r || out_ready) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= f_v_r;
        end
      end else if (en && f_v_r) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag_r     <= a_tag_nxt;
      a_mag_r     <= a_mag_nxt;
      dv_r[0]     <= dv_nxt[0];
      dv_tag_r[0] <= a_tag_r;
      for (int k = 0; k < DIV_W; k++) begin
        dv_r[k+1]     <= dv_nxt[k+1];
        dv_tag_r[k+1] <= dv_tag_r[k];
      end
      f_data_r <= f_data_nxt;
    end
    if (!out_v_r || out_ready) begin
      out_data_r <= skid_v_r ? skid_data_r : f_data_r;
    end else if (en && f_v_r) begin
      skid_data_r <= f_data_r;
    end
  end

endmodule
